### sv/stok_pkg.sv
`timescale 1ns / 1ps

package stok_pkg;

   localparam int POS_BITS_DEF = 16;

   // scanner modes
   typedef enum logic [2:0] {
      M_IDLE   = 3'd0,
      M_LINEC  = 3'd1,
      M_PARENC = 3'd2,
      M_WORD   = 3'd3,
      M_CHOPEN = 3'd4,
      M_CHBODY = 3'd5,
      M_STR    = 3'd6
   } mode_type;

   localparam logic [2:0] KIND_WORD = 3'd0;
   localparam logic [2:0] KIND_INT  = 3'd1;
   localparam logic [2:0] KIND_CHAR = 3'd2;
   localparam logic [2:0] KIND_STR  = 3'd3;
   localparam logic [2:0] KIND_ERR  = 3'd4;
   localparam logic [2:0] KIND_END  = 3'd5;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_EMPTY_CH  = 3'd1;
   localparam logic [2:0] ERR_BAD_CH    = 3'd2;
   localparam logic [2:0] ERR_MULTILINE = 3'd3;
   localparam logic [2:0] ERR_UNTERM    = 3'd4;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_LO_B   = 8'h62;
   localparam logic [7:0] CH_LO_O   = 8'h6f;
   localparam logic [7:0] CH_LO_X   = 8'h78;
   localparam logic [7:0] CH_UP_B   = 8'h42;
   localparam logic [7:0] CH_UP_O   = 8'h4f;
   localparam logic [7:0] CH_UP_X   = 8'h58;

   // number prefix classes
   localparam logic [2:0] CLS_NONE = 3'd0;
   localparam logic [2:0] CLS_ZERO = 3'd1;
   localparam logic [2:0] CLS_BIN  = 3'd2;
   localparam logic [2:0] CLS_OCT  = 3'd3;
   localparam logic [2:0] CLS_HEX  = 3'd4;

   typedef struct packed {
      logic [7:0] ch;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  err_code;
      logic [15:0] start_offset;
      logic [15:0] tok_length;
      logic [15:0] origin_line;
      logic [15:0] origin_col;
      logic        run_last;
   } rsp_type;

   function automatic logic [4:0] digit_value(logic [7:0] c);
      logic [4:0] v;
      v = 5'd16;
      if (c inside {[8'h30:8'h39]}) v = 5'(c - 8'h30);
      else if (c inside {[8'h61:8'h66]}) v = 5'(c - 8'h61 + 8'd10);
      else if (c inside {[8'h41:8'h46]}) v = 5'(c - 8'h41 + 8'd10);
      return v;
   endfunction

   // flags: [2:0] bytes seen (sat 7), [3] sign, [6:4] prefix class, [7] digits ok
   function automatic logic [7:0] word_update(logic [7:0] f, logic [7:0] c);
      logic [2:0] p;
      logic       s;
      logic [2:0] cls;
      logic       ok;
      logic [2:0] rel;
      logic [4:0] dv;
      logic [4:0] base;
      p   = f[2:0];
      s   = f[3];
      cls = f[6:4];
      ok  = f[7];
      rel = p - {2'b00, s};
      dv  = digit_value(c);
      case (cls)
         CLS_BIN: base = 5'd2;
         CLS_OCT: base = 5'd8;
         CLS_HEX: base = 5'd16;
         default: base = 5'd10;
      endcase
      if (p == 3'd0 && (c inside {CH_MINUS, CH_PLUS})) begin
         s = 1'b1;
      end else if (rel == 3'd0) begin
         if (c == CH_ZERO) cls = CLS_ZERO;
         if (dv >= 5'd10) ok = 1'b0;
      end else if (rel == 3'd1 && cls == CLS_ZERO &&
                   (c inside {CH_LO_B, CH_UP_B, CH_LO_O, CH_UP_O, CH_LO_X, CH_UP_X})) begin
         if (c inside {CH_LO_B, CH_UP_B}) cls = CLS_BIN;
         else if (c inside {CH_LO_O, CH_UP_O}) cls = CLS_OCT;
         else cls = CLS_HEX;
         ok = 1'b1;
      end else begin
         if (dv >= base) ok = 1'b0;
      end
      if (p != 3'd7) p = p + 3'd1;
      return {ok, cls, s, p};
   endfunction

   function automatic logic word_is_int(logic [7:0] f);
      logic r;
      if (!f[7]) r = 1'b0;
      else if (f[6:4] >= CLS_BIN) r = (f[2:0] >= 3'd4);
      else r = (f[2:0] > {2'b00, f[3]});
      return r;
   endfunction

endpackage

### sv/stok_scan.sv
`timescale 1ns / 1ps

module stok_scan #(
   parameter int POS_BITS = stok_pkg::POS_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  stok_pkg::req_type        req,
   output stok_pkg::rsp_type [2:0]  res,
   output logic [1:0]               res_cnt
);

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   typedef struct packed {
      stok_pkg::mode_type  mode;
      logic [POS_BITS-1:0] tstart;
      logic [POS_BITS-1:0] tline;
      logic [POS_BITS-1:0] tcol;
      logic [7:0]          flags;
   } tok_type;

   typedef struct packed {
      tok_type           tok;
      logic              emit;
      logic              redo;
      stok_pkg::rsp_type res;
   } pass_type;

   tok_type             tok_ff, tok_in, tok_after;
   logic [POS_BITS-1:0] offset_ff, offset_in;
   logic [POS_BITS-1:0] line_ff, line_in;
   logic [POS_BITS-1:0] col_ff, col_in;
   logic                seen_ff, seen_in;
   logic [POS_BITS-1:0] line_n, col_n, nxt;
   pass_type            p1, p2;
   stok_pkg::rsp_type   cand [4];
   logic [3:0]          cand_v;

   function automatic logic [POS_BITS-1:0] sat_inc(logic [POS_BITS-1:0] v);
      return (v == POS_MAX) ? v : v + POS_BITS'(1);
   endfunction

   function automatic stok_pkg::rsp_type mk_rsp(logic [2:0] kind, logic [2:0] err,
                                                logic [POS_BITS-1:0] start,
                                                logic [POS_BITS-1:0] len,
                                                logic [POS_BITS-1:0] line,
                                                logic [POS_BITS-1:0] col);
      stok_pkg::rsp_type r;
      r.kind         = kind;
      r.err_code     = err;
      r.start_offset = 16'(start);
      r.tok_length   = 16'(len);
      r.origin_line  = 16'(line);
      r.origin_col   = 16'(col);
      r.run_last     = 1'b0;
      return r;
   endfunction

   function automatic stok_pkg::rsp_type mk_err(tok_type t, logic [2:0] err);
      return mk_rsp(stok_pkg::KIND_ERR, err, t.tstart, '0, t.tline, t.tcol);
   endfunction

   function automatic stok_pkg::rsp_type mk_word(tok_type t, logic [POS_BITS-1:0] end_pos);
      return mk_rsp(stok_pkg::word_is_int(t.flags) ? stok_pkg::KIND_INT : stok_pkg::KIND_WORD,
                    stok_pkg::ERR_NONE, t.tstart, end_pos - t.tstart, t.tline, t.tcol);
   endfunction

   // one pass of the byte through the mode logic
   function automatic pass_type feed(tok_type t, logic [7:0] c, logic [POS_BITS-1:0] pos,
                                     logic [POS_BITS-1:0] nx, logic [POS_BITS-1:0] line,
                                     logic [POS_BITS-1:0] col);
      pass_type p;
      p.tok  = t;
      p.emit = 1'b0;
      p.redo = 1'b0;
      p.res  = '0;
      case (t.mode)
         stok_pkg::M_IDLE: begin
            if (c inside {stok_pkg::CH_SPACE, stok_pkg::CH_TAB, stok_pkg::CH_NL,
                          stok_pkg::CH_CR}) begin
               p.tok.mode = stok_pkg::M_IDLE;
            end else if (c == stok_pkg::CH_BSLASH) begin
               p.tok.mode = stok_pkg::M_LINEC;
            end else if (c == stok_pkg::CH_LPAREN) begin
               p.tok.mode = stok_pkg::M_PARENC;
            end else begin
               p.tok.tstart = pos;
               p.tok.tline  = line;
               p.tok.tcol   = col;
               if (c == stok_pkg::CH_SQUOTE) p.tok.mode = stok_pkg::M_CHOPEN;
               else if (c == stok_pkg::CH_DQUOTE) p.tok.mode = stok_pkg::M_STR;
               else begin
                  p.tok.mode  = stok_pkg::M_WORD;
                  p.tok.flags = stok_pkg::word_update(8'h80, c);
               end
            end
         end
         stok_pkg::M_LINEC: begin
            if (c == stok_pkg::CH_NL) p.tok.mode = stok_pkg::M_IDLE;
         end
         stok_pkg::M_PARENC: begin
            if (c == stok_pkg::CH_RPAREN) p.tok.mode = stok_pkg::M_IDLE;
         end
         stok_pkg::M_WORD: begin
            if (c inside {stok_pkg::CH_SPACE, stok_pkg::CH_TAB, stok_pkg::CH_NL}) begin
               p.emit     = 1'b1;
               p.res      = mk_word(t, pos);
               p.tok.mode = stok_pkg::M_IDLE;
            end else begin
               p.tok.flags = stok_pkg::word_update(t.flags, c);
            end
         end
         stok_pkg::M_CHOPEN: begin
            if (c == stok_pkg::CH_SQUOTE) begin
               p.emit     = 1'b1;
               p.redo     = 1'b1;
               p.res      = mk_err(t, stok_pkg::ERR_EMPTY_CH);
               p.tok.mode = stok_pkg::M_IDLE;
            end else begin
               p.tok.mode = stok_pkg::M_CHBODY;
            end
         end
         stok_pkg::M_CHBODY: begin
            p.emit     = 1'b1;
            p.tok.mode = stok_pkg::M_IDLE;
            if (c == stok_pkg::CH_SQUOTE) begin
               p.res = mk_rsp(stok_pkg::KIND_CHAR, stok_pkg::ERR_NONE, t.tstart,
                              nx - t.tstart, t.tline, t.tcol);
            end else begin
               p.redo = 1'b1;
               p.res  = mk_err(t, stok_pkg::ERR_BAD_CH);
            end
         end
         stok_pkg::M_STR: begin
            if (c == stok_pkg::CH_DQUOTE) begin
               p.emit     = 1'b1;
               p.res      = mk_rsp(stok_pkg::KIND_STR, stok_pkg::ERR_NONE, t.tstart,
                                   nx - t.tstart, t.tline, t.tcol);
               p.tok.mode = stok_pkg::M_IDLE;
            end else if (c == stok_pkg::CH_NL) begin
               p.emit     = 1'b1;
               p.redo     = 1'b1;
               p.res      = mk_err(t, stok_pkg::ERR_MULTILINE);
               p.tok.mode = stok_pkg::M_IDLE;
            end
         end
         default: begin
            p.tok.mode = stok_pkg::M_IDLE;
            p.redo     = 1'b1;
         end
      endcase
      return p;
   endfunction

   // both passes and the candidate results
   always_comb begin
      if (!seen_ff) begin
         line_n = line_ff;
         col_n  = col_ff;
      end else if (req.ch == stok_pkg::CH_NL) begin
         line_n = sat_inc(line_ff);
         col_n  = '0;
      end else begin
         line_n = line_ff;
         col_n  = sat_inc(col_ff);
      end
      nxt = sat_inc(offset_ff);

      p1 = feed(tok_ff, req.ch, offset_ff, nxt, line_n, col_n);
      p2 = feed(p1.tok, req.ch, offset_ff, nxt, line_n, col_n);
      tok_after = p1.redo ? p2.tok : p1.tok;

      cand[0]   = p1.res;
      cand_v[0] = p1.emit;
      cand[1]   = p2.res;
      cand_v[1] = p1.redo && p2.emit;
      cand_v[2] = req.final_byte;
      case (tok_after.mode)
         stok_pkg::M_WORD:   cand[2] = mk_word(tok_after, nxt);
         stok_pkg::M_STR:    cand[2] = mk_err(tok_after, stok_pkg::ERR_UNTERM);
         stok_pkg::M_CHOPEN,
         stok_pkg::M_CHBODY: cand[2] = mk_err(tok_after, stok_pkg::ERR_BAD_CH);
         default: begin
            cand[2]   = '0;
            cand_v[2] = 1'b0;
         end
      endcase
      cand[3]   = mk_rsp(stok_pkg::KIND_END, stok_pkg::ERR_NONE, nxt, '0, line_n,
                         sat_inc(col_n));
      cand_v[3] = req.final_byte;
   end

   // pack the valid candidates in order, mark the last one
   always_comb begin
      logic [1:0] n;
      n   = 2'd0;
      res = '0;
      for (int i = 0; i < 4; i++) begin
         if (cand_v[i] && n != 2'd3) begin
            res[n] = cand[i];
            n      = n + 2'd1;
         end
      end
      if (n != 2'd0) res[n - 2'd1].run_last = 1'b1;
      res_cnt = n;
   end

   // next state
   always_comb begin
      tok_in    = tok_ff;
      offset_in = offset_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      seen_in   = seen_ff;
      if (accept) begin
         if (req.final_byte) begin
            tok_in    = '{mode: stok_pkg::M_IDLE, tstart: '0, tline: '0, tcol: '0, flags: '0};
            offset_in = '0;
            line_in   = '0;
            col_in    = '0;
            seen_in   = 1'b0;
         end else begin
            tok_in    = tok_after;
            offset_in = nxt;
            line_in   = line_n;
            col_in    = col_n;
            seen_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff    <= '{mode: stok_pkg::M_IDLE, tstart: '0, tline: '0, tcol: '0, flags: '0};
         offset_ff <= '0;
         line_ff   <= '0;
         col_ff    <= '0;
         seen_ff   <= 1'b0;
      end else begin
         tok_ff    <= tok_in;
         offset_ff <= offset_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

### sv/source_tokenizer.sv
`timescale 1ns / 1ps

// Streaming source tokenizer. One source byte is taken per cycle while
// req_ready is high; its tokens (up to three: a rejected char literal or
// string error, a token started by the reprocessed byte and flushed by the
// final byte, and the end marker on the final byte) are registered in a
// four-entry result queue and leave it in order, one per cycle while the
// result side is ready. Input is accepted whenever at most one result is
// queued, so with the result side always ready bytes flow at one per cycle
// as long as each yields at most one token; a byte that yields more tokens
// holds the input while the queue drains. Positions, lines and columns are
// POS_BITS wide internally, saturate, and are reported in their low 16 bits.
module source_tokenizer #(
   parameter int POS_BITS = stok_pkg::POS_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stok_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stok_pkg::rsp_type rsp_data
);

   localparam int QDEPTH = 4;

   stok_pkg::rsp_type [2:0] res;
   logic [1:0]              res_cnt;
   logic                    req_fire, rsp_fire;

   stok_pkg::rsp_type       queue_ff [QDEPTH];
   logic [1:0]              wr_ff, wr_in;
   logic [1:0]              rd_ff, rd_in;
   logic [2:0]              count_ff, count_in;

   assign req_ready = (count_ff <= 3'd1);
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = queue_ff[rd_ff];
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   stok_scan #(
      .POS_BITS (POS_BITS)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_fire),
      .req     (req_data),
      .res     (res),
      .res_cnt (res_cnt)
   );

   always_comb begin
      logic [1:0] push;
      push     = req_fire ? res_cnt : 2'd0;
      wr_in    = wr_ff + push;
      rd_in    = rd_ff + {1'b0, rsp_fire};
      count_in = count_ff + {1'b0, push} - {2'b00, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (req_fire && 2'(i) < res_cnt) queue_ff[wr_ff + 2'(i)] <= res[i];
      end
   end

   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(QDEPTH))
      else $error("result queue overflow");

   a_final_has_end : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.final_byte |-> res_cnt != 2'd0 &&
      res[res_cnt - 2'd1].kind == stok_pkg::KIND_END)
      else $error("final byte without end result");

   a_end_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_data.kind == stok_pkg::KIND_END |-> rsp_data.run_last)
      else $error("end result not marked last");

endmodule

### tb/sv/source_tokenizer_test.sv
`timescale 1ns / 1ps

module source_tokenizer_test;

   localparam int                HALF_PERIOD = 5;
   localparam int                ITEMS_GOAL  = 310;
   localparam int                NUM_ROWS    = 26;
   localparam logic [15:0]       POS_TOP     = 16'hffff;
   localparam stok_pkg::rsp_type NO_TOK      = '0;

   typedef struct packed {
      stok_pkg::req_type item;
      logic              typed;
      stok_pkg::rsp_type want;
   } dir_row_type;

   // Hand-checked rows carry their token; the rest go through the scanner copy.
   localparam dir_row_type DIR_ROWS [NUM_ROWS] = '{
      '{'{stok_pkg::CH_SQUOTE, 1'b0}, 1'b0, NO_TOK},
      '{'{stok_pkg::CH_SQUOTE, 1'b0}, 1'b1,
        '{stok_pkg::KIND_ERR, stok_pkg::ERR_EMPTY_CH, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}},
      '{'{"a", 1'b0}, 1'b0, NO_TOK},
      '{'{"b", 1'b0}, 1'b1,
        '{stok_pkg::KIND_ERR, stok_pkg::ERR_BAD_CH, 16'd1, 16'd0, 16'd0, 16'd1, 1'b1}},
      '{'{stok_pkg::CH_SPACE, 1'b0}, 1'b1,
        '{stok_pkg::KIND_WORD, stok_pkg::ERR_NONE, 16'd3, 16'd1, 16'd0, 16'd3, 1'b1}},
      '{'{stok_pkg::CH_DQUOTE, 1'b0}, 1'b0, NO_TOK},
      '{'{"q", 1'b0}, 1'b0, NO_TOK},
      '{'{stok_pkg::CH_NL, 1'b0}, 1'b1,
        '{stok_pkg::KIND_ERR, stok_pkg::ERR_MULTILINE, 16'd5, 16'd0, 16'd0, 16'd5, 1'b1}},
      '{'{stok_pkg::CH_MINUS, 1'b0}, 1'b0, NO_TOK},
      '{'{stok_pkg::CH_ZERO, 1'b0}, 1'b0, NO_TOK},
      '{'{stok_pkg::CH_UP_X, 1'b0}, 1'b0, NO_TOK},
      '{'{"F", 1'b0}, 1'b0, NO_TOK},
      '{'{stok_pkg::CH_TAB, 1'b0}, 1'b1,
        '{stok_pkg::KIND_INT, stok_pkg::ERR_NONE, 16'd8, 16'd4, 16'd1, 16'd1, 1'b1}},
      '{'{stok_pkg::CH_BSLASH, 1'b0}, 1'b0, NO_TOK},
      '{'{8'hff, 1'b0}, 1'b0, NO_TOK},
      '{'{stok_pkg::CH_NL, 1'b0}, 1'b0, NO_TOK},
      '{'{stok_pkg::CH_LPAREN, 1'b0}, 1'b0, NO_TOK},
      '{'{8'h00, 1'b0}, 1'b0, NO_TOK},
      '{'{stok_pkg::CH_RPAREN, 1'b0}, 1'b0, NO_TOK},
      '{'{stok_pkg::CH_SQUOTE, 1'b0}, 1'b0, NO_TOK},
      '{'{"z", 1'b0}, 1'b0, NO_TOK},
      '{'{stok_pkg::CH_SQUOTE, 1'b0}, 1'b0, NO_TOK},
      '{'{stok_pkg::CH_SQUOTE, 1'b0}, 1'b0, NO_TOK},
      '{'{"a", 1'b0}, 1'b0, NO_TOK},
      '{'{"b", 1'b1}, 1'b0, NO_TOK},
      '{'{stok_pkg::CH_SPACE, 1'b1}, 1'b1,
        '{stok_pkg::KIND_END, stok_pkg::ERR_NONE, 16'd1, 16'd0, 16'd0, 16'd1, 1'b1}}
   };

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   stok_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   stok_pkg::rsp_type rsp_data;

   source_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // scanner copy
   stok_pkg::mode_type scan_mode;
   logic [15:0]        byte_pos;
   logic [15:0]        line_no;
   logic [15:0]        col_no;
   logic [15:0]        tok_pos;
   logic [15:0]        tok_line;
   logic [15:0]        tok_col;
   logic               started;
   logic [7:0]         int_flags;

   stok_pkg::rsp_type byte_tokens [$];
   stok_pkg::rsp_type due_tokens [$];
   logic [7:0]        frag [$];
   logic              frag_final;

   int idle_pct     = 15;
   int fail_count   = 0;
   int bytes_sent   = 0;
   int toks_checked = 0;
   int texts_done   = 0;

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("%0t: timeout with %0d tokens outstanding", $time, due_tokens.size());
      $display("Verification failed");
      $finish;
   end

   function automatic logic [15:0] sat_up(logic [15:0] v);
      return (v == POS_TOP) ? v : v + 16'd1;
   endfunction

   function automatic logic [4:0] digit_of(logic [7:0] c);
      logic [7:0] lc;
      lc = c | 8'h20;
      if (c >= stok_pkg::CH_ZERO && c <= "9") return 5'(c - stok_pkg::CH_ZERO);
      if (lc >= "a" && lc <= "f") return 5'(lc - "a" + 8'd10);
      return 5'd16;
   endfunction

   // flags: [2:0] bytes seen (sat 7), [3] sign, [6:4] prefix class, [7] digits ok
   function automatic logic [7:0] int_flags_next(logic [7:0] f, logic [7:0] c);
      logic [2:0] cnt;
      logic [2:0] cls;
      logic [2:0] idx;
      logic       sgn;
      logic       ok;
      logic [4:0] radix;
      logic [7:0] lc;
      cnt = f[2:0];
      sgn = f[3];
      cls = f[6:4];
      ok  = f[7];
      idx = cnt - 3'(sgn);
      lc  = c | 8'h20;
      case (cls)
         stok_pkg::CLS_BIN: radix = 5'd2;
         stok_pkg::CLS_OCT: radix = 5'd8;
         stok_pkg::CLS_HEX: radix = 5'd16;
         default: radix = 5'd10;
      endcase
      if (cnt == 3'd0 && (c == stok_pkg::CH_PLUS || c == stok_pkg::CH_MINUS)) begin
         sgn = 1'b1;
      end else if (idx == 3'd0) begin
         if (c == stok_pkg::CH_ZERO) cls = stok_pkg::CLS_ZERO;
         if (digit_of(c) > 5'd9) ok = 1'b0;
      end else if (idx == 3'd1 && cls == stok_pkg::CLS_ZERO &&
                   (lc == stok_pkg::CH_LO_B || lc == stok_pkg::CH_LO_O ||
                    lc == stok_pkg::CH_LO_X)) begin
         cls = (lc == stok_pkg::CH_LO_B) ? stok_pkg::CLS_BIN :
               (lc == stok_pkg::CH_LO_O) ? stok_pkg::CLS_OCT : stok_pkg::CLS_HEX;
         ok  = 1'b1;
      end else if (digit_of(c) >= radix) begin
         ok = 1'b0;
      end
      if (cnt != 3'd7) cnt = cnt + 3'd1;
      return {ok, cls, sgn, cnt};
   endfunction

   function automatic logic flags_say_int(logic [7:0] f);
      if (!f[7]) return 1'b0;
      if (f[6:4] >= stok_pkg::CLS_BIN) return f[2:0] >= 3'd4;
      return f[2:0] > 3'(f[3]);
   endfunction

   function automatic void add_tok(logic [2:0] kind, logic [2:0] err, logic [15:0] start,
                                   logic [15:0] len, logic [15:0] line, logic [15:0] col);
      byte_tokens.push_back('{kind, err, start, len, line, col, 1'b0});
   endfunction

   function automatic void add_word(logic [15:0] end_pos);
      add_tok(flags_say_int(int_flags) ? stok_pkg::KIND_INT : stok_pkg::KIND_WORD,
              stok_pkg::ERR_NONE, tok_pos, end_pos - tok_pos, tok_line, tok_col);
   endfunction

   function automatic void add_err(logic [2:0] code);
      add_tok(stok_pkg::KIND_ERR, code, tok_pos, 16'd0, tok_line, tok_col);
   endfunction

   function automatic void clear_scanner();
      scan_mode = stok_pkg::M_IDLE;
      byte_pos  = '0;
      line_no   = '0;
      col_no    = '0;
      started   = 1'b0;
      tok_pos   = '0;
      tok_line  = '0;
      tok_col   = '0;
      int_flags = '0;
   endfunction

   // returns 1 when the byte was rejected and has to be scanned again from idle
   function automatic logic scan_byte(logic [7:0] c, logic [15:0] here, logic [15:0] after);
      logic redo;
      redo = 1'b0;
      case (scan_mode)
         stok_pkg::M_IDLE: begin
            if (c == stok_pkg::CH_BSLASH) begin
               scan_mode = stok_pkg::M_LINEC;
            end else if (c == stok_pkg::CH_LPAREN) begin
               scan_mode = stok_pkg::M_PARENC;
            end else if (!(c inside {stok_pkg::CH_SPACE, stok_pkg::CH_TAB, stok_pkg::CH_NL,
                                     stok_pkg::CH_CR})) begin
               tok_pos  = here;
               tok_line = line_no;
               tok_col  = col_no;
               if (c == stok_pkg::CH_SQUOTE) begin
                  scan_mode = stok_pkg::M_CHOPEN;
               end else if (c == stok_pkg::CH_DQUOTE) begin
                  scan_mode = stok_pkg::M_STR;
               end else begin
                  scan_mode = stok_pkg::M_WORD;
                  int_flags = int_flags_next(8'h80, c);
               end
            end
         end
         stok_pkg::M_LINEC: if (c == stok_pkg::CH_NL) scan_mode = stok_pkg::M_IDLE;
         stok_pkg::M_PARENC: if (c == stok_pkg::CH_RPAREN) scan_mode = stok_pkg::M_IDLE;
         stok_pkg::M_WORD: begin
            if (c inside {stok_pkg::CH_SPACE, stok_pkg::CH_TAB, stok_pkg::CH_NL}) begin
               add_word(here);
               scan_mode = stok_pkg::M_IDLE;
            end else begin
               int_flags = int_flags_next(int_flags, c);
            end
         end
         stok_pkg::M_CHOPEN: begin
            if (c == stok_pkg::CH_SQUOTE) begin
               add_err(stok_pkg::ERR_EMPTY_CH);
               scan_mode = stok_pkg::M_IDLE;
               redo = 1'b1;
            end else begin
               scan_mode = stok_pkg::M_CHBODY;
            end
         end
         stok_pkg::M_CHBODY: begin
            scan_mode = stok_pkg::M_IDLE;
            if (c == stok_pkg::CH_SQUOTE) begin
               add_tok(stok_pkg::KIND_CHAR, stok_pkg::ERR_NONE, tok_pos, after - tok_pos,
                       tok_line, tok_col);
            end else begin
               add_err(stok_pkg::ERR_BAD_CH);
               redo = 1'b1;
            end
         end
         stok_pkg::M_STR: begin
            if (c == stok_pkg::CH_DQUOTE) begin
               add_tok(stok_pkg::KIND_STR, stok_pkg::ERR_NONE, tok_pos, after - tok_pos,
                       tok_line, tok_col);
               scan_mode = stok_pkg::M_IDLE;
            end else if (c == stok_pkg::CH_NL) begin
               add_err(stok_pkg::ERR_MULTILINE);
               scan_mode = stok_pkg::M_IDLE;
               redo = 1'b1;
            end
         end
         default: begin
            scan_mode = stok_pkg::M_IDLE;
            redo = 1'b1;
         end
      endcase
      return redo;
   endfunction

   task automatic lex_byte(stok_pkg::req_type item);
      logic [15:0]       here;
      logic [15:0]       after;
      stok_pkg::rsp_type last_tok;
      if (!started) begin
         started = 1'b1;
      end else if (item.ch == stok_pkg::CH_NL) begin
         line_no = sat_up(line_no);
         col_no  = '0;
      end else begin
         col_no = sat_up(col_no);
      end
      here  = byte_pos;
      after = sat_up(byte_pos);
      if (scan_byte(item.ch, here, after)) void'(scan_byte(item.ch, here, after));
      byte_pos = after;
      if (item.final_byte) begin
         case (scan_mode)
            stok_pkg::M_WORD: add_word(byte_pos);
            stok_pkg::M_STR: add_err(stok_pkg::ERR_UNTERM);
            stok_pkg::M_CHOPEN, stok_pkg::M_CHBODY: add_err(stok_pkg::ERR_BAD_CH);
            default: ;
         endcase
         add_tok(stok_pkg::KIND_END, stok_pkg::ERR_NONE, byte_pos, 16'd0, line_no,
                 sat_up(col_no));
         texts_done++;
         clear_scanner();
      end
      if (byte_tokens.size() > 0) begin
         last_tok = byte_tokens.pop_back();
         last_tok.run_last = 1'b1;
         byte_tokens.push_back(last_tok);
      end
   endtask

   task automatic send_byte(logic [7:0] c, logic fin, logic typed = 1'b0,
                            stok_pkg::rsp_type want = '0);
      stok_pkg::req_type item;
      item = '{c, fin};
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      bytes_sent++;
      lex_byte(item);
      if (typed) begin
         due_tokens.push_back(want);
      end else begin
         foreach (byte_tokens[i]) due_tokens.push_back(byte_tokens[i]);
      end
      byte_tokens.delete();
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_tokens.size() != 0);
   endtask

   // One random lexical piece: mostly well-formed tokens, some broken ones and noise.
   task automatic build_fragment();
      int         pick;
      int         n;
      int         v;
      logic [4:0] radix;
      logic [7:0] c;
      frag.delete();
      pick = $urandom_range(99);
      if (pick < 30) begin
         if ($urandom_range(2) == 0) begin
            frag.push_back($urandom_range(1) ? stok_pkg::CH_MINUS : stok_pkg::CH_PLUS);
         end
         radix = 5'd10;
         if ($urandom_range(1)) begin
            frag.push_back(stok_pkg::CH_ZERO);
            case ($urandom_range(3))
               0: begin
                  frag.push_back($urandom_range(1) ? stok_pkg::CH_LO_B : stok_pkg::CH_UP_B);
                  radix = 5'd2;
               end
               1: begin
                  frag.push_back($urandom_range(1) ? stok_pkg::CH_LO_O : stok_pkg::CH_UP_O);
                  radix = 5'd8;
               end
               2: begin
                  frag.push_back($urandom_range(1) ? stok_pkg::CH_LO_X : stok_pkg::CH_UP_X);
                  radix = 5'd16;
               end
               default: ;
            endcase
         end
         n = $urandom_range(4);
         repeat (n) begin
            v = $urandom_range(int'(radix) - 1);
            if (v < 10) c = 8'(stok_pkg::CH_ZERO + v);
            else c = 8'(($urandom_range(1) ? "A" : "a") + v - 10);
            frag.push_back(c);
         end
         if ($urandom_range(7) == 0) frag.push_back(8'($urandom_range(8'h7a, 8'h30)));
      end else if (pick < 45) begin
         frag.push_back(8'($urandom_range("z", "a")));
         n = $urandom_range(5);
         repeat (n) frag.push_back(8'($urandom_range(8'h7e, 8'h21)));
      end else if (pick < 57) begin
         frag.push_back(stok_pkg::CH_SQUOTE);
         case ($urandom_range(4))
            0: ;
            1: frag.push_back(8'($urandom_range(8'h7e, 8'h20)));
            2: frag.push_back(stok_pkg::CH_NL);
            default: frag.push_back(8'($urandom_range(255)));
         endcase
         if ($urandom_range(3) != 0) frag.push_back(stok_pkg::CH_SQUOTE);
      end else if (pick < 69) begin
         frag.push_back(stok_pkg::CH_DQUOTE);
         n = $urandom_range(5);
         repeat (n) begin
            c = 8'($urandom_range(8'h7e, 8'h20));
            if (c == stok_pkg::CH_DQUOTE) c = "_";
            if ($urandom_range(11) == 0) c = stok_pkg::CH_NL;
            frag.push_back(c);
         end
         if ($urandom_range(5) != 0) frag.push_back(stok_pkg::CH_DQUOTE);
      end else if (pick < 77) begin
         frag.push_back($urandom_range(1) ? stok_pkg::CH_BSLASH : stok_pkg::CH_LPAREN);
         n = $urandom_range(4);
         repeat (n) frag.push_back(8'($urandom_range(255)));
         frag.push_back(frag[0] == stok_pkg::CH_BSLASH ? stok_pkg::CH_NL : stok_pkg::CH_RPAREN);
      end else if (pick < 90) begin
         n = $urandom_range(3, 1);
         repeat (n) begin
            case ($urandom_range(3))
               0: frag.push_back(stok_pkg::CH_SPACE);
               1: frag.push_back(stok_pkg::CH_TAB);
               2: frag.push_back(stok_pkg::CH_NL);
               default: frag.push_back(stok_pkg::CH_CR);
            endcase
         end
      end else begin
         n = $urandom_range(4, 1);
         repeat (n) frag.push_back(8'($urandom_range(255)));
      end
      if (pick < 69 && $urandom_range(4) != 0) begin
         case ($urandom_range(2))
            0: frag.push_back(stok_pkg::CH_SPACE);
            1: frag.push_back(stok_pkg::CH_TAB);
            default: frag.push_back(stok_pkg::CH_NL);
         endcase
      end
      frag_final = ($urandom_range(11) == 0);
   endtask

   task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      stok_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (due_tokens.size() == 0) begin
            fail_count++;
            $display("%0t: token with nothing outstanding: expected none, actual %p",
                     $time, rsp_data);
         end else begin
            want = due_tokens.pop_front();
            toks_checked++;
            cmp_field("kind", 16'(want.kind), 16'(rsp_data.kind));
            cmp_field("err_code", 16'(want.err_code), 16'(rsp_data.err_code));
            cmp_field("start_offset", want.start_offset, rsp_data.start_offset);
            cmp_field("tok_length", want.tok_length, rsp_data.tok_length);
            cmp_field("origin_line", want.origin_line, rsp_data.origin_line);
            cmp_field("origin_col", want.origin_col, rsp_data.origin_col);
            cmp_field("run_last", 16'(want.run_last), 16'(rsp_data.run_last));
         end
      end
   end

   initial begin
      int wait_cycles;
      clear_scanner();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIR_ROWS[i]) begin
         send_byte(DIR_ROWS[i].item.ch, DIR_ROWS[i].item.final_byte, DIR_ROWS[i].typed,
                   DIR_ROWS[i].want);
      end
      drain_results();

      while (bytes_sent < ITEMS_GOAL - 1) begin
         // a quiet stretch in the middle of the random part
         idle_pct = (bytes_sent > 150 && bytes_sent < 230) ? 0 : 15;
         build_fragment();
         foreach (frag[i]) send_byte(frag[i], frag_final && i == frag.size() - 1);
         if ($urandom_range(19) == 0) drain_results();
      end
      idle_pct = 15;
      send_byte(stok_pkg::CH_SPACE, 1'b1);

      req_valid <= 1'b0;
      wait_cycles = 0;
      while (due_tokens.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (due_tokens.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected tokens never arrived", $time, due_tokens.size());
      end

      $display("Ran %0d bytes over %0d source texts and checked %0d tokens: words, numbers,",
               bytes_sent, texts_done, toks_checked);
      $display("literals, comments, broken tokens, stalls and a gap-free stretch; %0d errors.",
               fail_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
